// File: rtl/rpc_pkg.sv
// Shared types, constants and helper functions for the 3-D point rotator.
`default_nettype none
package rpc_pkg;

  localparam int COORD_W   = 24;
  localparam int FRAC_BITS = 8;
  localparam int PIX_W     = 16;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  localparam int ANGLE_X_RST  = 13;
  localparam int ANGLE_Y_RST  = 7;
  localparam int ANGLE_Z_RST  = 26;
  localparam int CENTRE_RST   = 38400;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PIX_W-1:0]   pix_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANGLE_X,
    CFG_ANGLE_Y,
    CFG_ANGLE_Z,
    CFG_CENTRE_X,
    CFG_CENTRE_Y,
    CFG_CENTRE_Z
  } cfg_reg_t;

  typedef struct packed {
    coord_t in_x;
    coord_t in_y;
    coord_t in_z;
  } vtx_in_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    pix_t   pixel_x;
    pix_t   pixel_y;
    logic   clipped;
  } vtx_out_t;

  // One vertex moving along the rotation chain: p and q are the pair
  // being rotated, r rides along untouched.
  typedef struct packed {
    logic   valid;
    logic   clip;
    coord_t p;
    coord_t q;
    coord_t r;
  } rot_item_t;

  typedef struct packed {
    logic   clip;
    coord_t val;
  } sat_coord_t;

  typedef struct packed {
    logic clip;
    pix_t val;
  } sat_pix_t;

  // Saturate a value carrying one guard bit to the coordinate range.
  function automatic sat_coord_t sat_coord(input logic signed [COORD_W:0] v);
    sat_coord_t res;
    res.clip = (v[COORD_W] != v[COORD_W-1]);
    res.val  = res.clip ? {v[COORD_W], {(COORD_W-1){~v[COORD_W]}}} : v[COORD_W-1:0];
    return res;
  endfunction

  // Saturate a coordinate-width value to the pixel range.
  function automatic sat_pix_t sat_pix(input coord_t v);
    sat_pix_t res;
    res.clip = !((&v[COORD_W-1:PIX_W-1]) || !(|v[COORD_W-1:PIX_W-1]));
    res.val  = res.clip ? {v[COORD_W-1], {(PIX_W-1){~v[COORD_W-1]}}} : v[PIX_W-1:0];
    return res;
  endfunction

  // Quarter-wave sine entry: Taylor sum to x^13/13! in Q2.30, rounded to
  // tf fraction bits and clamped to [0, 2^tf]. Evaluated at elaboration.
  function automatic longint quarter_sine_f(input longint unsigned r, input int ab,
                                            input int tf);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    x    = (r * HALF_PI_Q30) >> (ab - 2);
    x2   = (x * x) >> 30;
    sum  = longint'(x);
    term = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    sum  = (sum + (longint'(1) <<< (29 - tf))) >>> (30 - tf);
    if (sum < 0) sum = 0;
    if (sum > (longint'(1) <<< tf)) sum = longint'(1) <<< tf;
    return sum;
  endfunction

endpackage
`default_nettype wire

// File: rtl/rotate_point_3d_about_centre.sv
// Top level of the 3-D point rotator: centre offset, X/Y/Z rotation chain, pixel output.
`default_nettype none
// Rotates each vertex (signed Q15.8) about the configured centre: the centre is
// subtracted, the vertex is rotated about X, then Y, then Z by the configured
// binary angles, and the centre is added back. One vertex is taken in every
// clock cycle while busy is low; its result appears on out_data with out_valid
// high for exactly one cycle, after passing through the chain: one input
// register, one centre subtract stage, two stages in each of the three rotation
// cells (multiply, then sum/round/saturate), one centre add stage and one output
// stage. The receiver cannot stall, so every result must be captured in the
// cycle it is shown. busy is high during reset and for the first cycle after
// it, and low from then on. Each rotation cell keeps its own sine/cosine ROM
// read from the angle registers; a new angle settles there through the ROM read
// register and the signed output register, which the pipeline already covers,
// so a vertex may be started in the cycle right after a configuration write.
// Every saturation (centre subtract, each rotation output, centre add, pixel
// range) sets clipped for that vertex.
module rotate_point_3d_about_centre
  import rpc_pkg::*;
#(
  parameter int ANGLE_BITS     = 12,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // vertex in
  input  wire logic                 start,
  output logic                      busy,
  input  wire vtx_in_t              in_data,
  // result out
  output logic                      out_valid,
  output vtx_out_t                  out_data,
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ANGLE_BITS-1:0] angle_x_r;
  logic [ANGLE_BITS-1:0] angle_y_r;
  logic [ANGLE_BITS-1:0] angle_z_r;
  coord_t                centre_x_r;
  coord_t                centre_y_r;
  coord_t                centre_z_r;

  // Writes to indexes past the register list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_x_r  <= ANGLE_BITS'(ANGLE_X_RST);
      angle_y_r  <= ANGLE_BITS'(ANGLE_Y_RST);
      angle_z_r  <= ANGLE_BITS'(ANGLE_Z_RST);
      centre_x_r <= COORD_W'(CENTRE_RST);
      centre_y_r <= COORD_W'(CENTRE_RST);
      centre_z_r <= COORD_W'(CENTRE_RST);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ANGLE_X:  angle_x_r  <= cfg_wdata[ANGLE_BITS-1:0];
        CFG_ANGLE_Y:  angle_y_r  <= cfg_wdata[ANGLE_BITS-1:0];
        CFG_ANGLE_Z:  angle_z_r  <= cfg_wdata[ANGLE_BITS-1:0];
        CFG_CENTRE_X: centre_x_r <= cfg_wdata[COORD_W-1:0];
        CFG_CENTRE_Y: centre_y_r <= cfg_wdata[COORD_W-1:0];
        CFG_CENTRE_Z: centre_z_r <= cfg_wdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input handshake: hold off only while the trig ROM outputs are priming.
  // ---------------------------------------------------------------------------
  logic busy_r;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // Capture the transaction.
  logic    v0_r;
  vtx_in_t in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Subtract the centre, saturate, and load the X cell (rotates y, z).
  // ---------------------------------------------------------------------------
  sat_coord_t sub_x;
  sat_coord_t sub_y;
  sat_coord_t sub_z;
  rot_item_t  s1_nxt;
  rot_item_t  s1_r;

  always_comb begin
    sub_x = sat_coord((COORD_W+1)'(in_r.in_x) - (COORD_W+1)'(centre_x_r));
    sub_y = sat_coord((COORD_W+1)'(in_r.in_y) - (COORD_W+1)'(centre_y_r));
    sub_z = sat_coord((COORD_W+1)'(in_r.in_z) - (COORD_W+1)'(centre_z_r));
    s1_nxt.valid = v0_r;
    s1_nxt.clip  = sub_x.clip | sub_y.clip | sub_z.clip;
    s1_nxt.p     = sub_y.val;
    s1_nxt.q     = sub_z.val;
    s1_nxt.r     = sub_x.val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
    end else begin
      s1_r <= s1_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Rotation chain. Re-route the pair between cells:
  //   X cell: p=y q=z r=x;  Y cell: p=x q=z r=y;  Z cell: p=x q=y r=z
  // ---------------------------------------------------------------------------
  rot_item_t cx_out;
  rot_item_t cy_in;
  rot_item_t cy_out;
  rot_item_t cz_in;
  rot_item_t cz_out;

  rpc_rot_cell #(
    .ANGLE_BITS     (ANGLE_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_cell_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .angle  (angle_x_r),
    .item_i (s1_r),
    .item_o (cx_out)
  );

  always_comb begin
    cy_in.valid = cx_out.valid;
    cy_in.clip  = cx_out.clip;
    cy_in.p     = cx_out.r;
    cy_in.q     = cx_out.q;
    cy_in.r     = cx_out.p;
  end

  rpc_rot_cell #(
    .ANGLE_BITS     (ANGLE_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_cell_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .angle  (angle_y_r),
    .item_i (cy_in),
    .item_o (cy_out)
  );

  always_comb begin
    cz_in.valid = cy_out.valid;
    cz_in.clip  = cy_out.clip;
    cz_in.p     = cy_out.p;
    cz_in.q     = cy_out.r;
    cz_in.r     = cy_out.q;
  end

  rpc_rot_cell #(
    .ANGLE_BITS     (ANGLE_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_cell_z (
    .clk    (clk),
    .rst_n  (rst_n),
    .angle  (angle_z_r),
    .item_i (cz_in),
    .item_o (cz_out)
  );

  // ---------------------------------------------------------------------------
  // Add the centre back and saturate (Z cell out: p=x q=y r=z).
  // ---------------------------------------------------------------------------
  sat_coord_t add_x;
  sat_coord_t add_y;
  sat_coord_t add_z;
  logic       e1_valid_r;
  logic       e1_clip_r;
  coord_t     e1_x_r;
  coord_t     e1_y_r;
  coord_t     e1_z_r;

  always_comb begin
    add_x = sat_coord((COORD_W+1)'(cz_out.p) + (COORD_W+1)'(centre_x_r));
    add_y = sat_coord((COORD_W+1)'(cz_out.q) + (COORD_W+1)'(centre_y_r));
    add_z = sat_coord((COORD_W+1)'(cz_out.r) + (COORD_W+1)'(centre_z_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_valid_r <= 1'b0;
    end else begin
      e1_valid_r <= cz_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    e1_clip_r <= cz_out.clip | add_x.clip | add_y.clip | add_z.clip;
    e1_x_r    <= add_x.val;
    e1_y_r    <= add_y.val;
    e1_z_r    <= add_z.val;
  end

  // ---------------------------------------------------------------------------
  // Pixel coordinates: floor by an arithmetic shift, then clamp to 16 bits.
  // ---------------------------------------------------------------------------
  sat_pix_t pix_x;
  sat_pix_t pix_y;
  vtx_out_t out_nxt;
  vtx_out_t out_r;
  logic     out_valid_r;

  always_comb begin
    pix_x = sat_pix(e1_x_r >>> FRAC_BITS);
    pix_y = sat_pix(e1_y_r >>> FRAC_BITS);
    out_nxt.out_x   = e1_x_r;
    out_nxt.out_y   = e1_y_r;
    out_nxt.out_z   = e1_z_r;
    out_nxt.pixel_x = pix_x.val;
    out_nxt.pixel_y = pix_y.val;
    out_nxt.clipped = e1_clip_r | pix_x.clip | pix_y.clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= e1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##10 out_valid)
    else $error("accepted transaction did not produce a result after 10 cycles");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 10))
    else $error("result strobe without a transaction accepted 10 cycles earlier");

  a_busy_after_prime: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside the post-reset priming cycle");

endmodule
`default_nettype wire

// File: rtl/rpc_trig.sv
// Sine and cosine lookup of one binary angle from a quarter-wave ROM.
`default_nettype none
module rpc_trig
  import rpc_pkg::*;
#(
  parameter int ANGLE_BITS     = 12,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  wire logic                              clk,
  input  wire logic [ANGLE_BITS-1:0]             angle,
  output logic signed [TRIG_FRAC_BITS+1:0]       sin_val,
  output logic signed [TRIG_FRAC_BITS+1:0]       cos_val
);

  localparam int QSIZE = 1 << (ANGLE_BITS - 2);
  localparam int IDX_W = ANGLE_BITS - 1;
  localparam int MAG_W = TRIG_FRAC_BITS + 1;
  localparam int TW    = TRIG_FRAC_BITS + 2;

  logic [MAG_W-1:0] qtab [QSIZE+1];

  for (genvar i = 0; i <= QSIZE; i++) begin : g_tab
    assign qtab[i] = MAG_W'(quarter_sine_f(64'(i), ANGLE_BITS, TRIG_FRAC_BITS));
  end

  logic [1:0]       sin_quad;
  logic [1:0]       cos_quad;
  logic [IDX_W-1:0] frac_idx;
  logic [IDX_W-1:0] sin_idx;
  logic [IDX_W-1:0] cos_idx;

  logic [MAG_W-1:0] sin_mag_r;
  logic [MAG_W-1:0] cos_mag_r;
  logic             sin_neg_r;
  logic             cos_neg_r;
  logic signed [TW-1:0] sin_r;
  logic signed [TW-1:0] cos_r;
  logic signed [TW-1:0] sin_nxt;
  logic signed [TW-1:0] cos_nxt;

  always_comb begin
    sin_quad = angle[ANGLE_BITS-1 -: 2];
    cos_quad = sin_quad + 2'd1;
    frac_idx = {1'b0, angle[ANGLE_BITS-3:0]};
    sin_idx  = sin_quad[0] ? IDX_W'(QSIZE) - frac_idx : frac_idx;
    cos_idx  = cos_quad[0] ? IDX_W'(QSIZE) - frac_idx : frac_idx;
  end

  // Registered ROM read, then apply the half-wave sign.
  always_ff @(posedge clk) begin
    sin_mag_r <= qtab[sin_idx];
    cos_mag_r <= qtab[cos_idx];
    sin_neg_r <= sin_quad[1];
    cos_neg_r <= cos_quad[1];
  end

  always_comb begin
    sin_nxt = sin_neg_r ? -$signed({1'b0, sin_mag_r}) : $signed({1'b0, sin_mag_r});
    cos_nxt = cos_neg_r ? -$signed({1'b0, cos_mag_r}) : $signed({1'b0, cos_mag_r});
  end

  always_ff @(posedge clk) begin
    sin_r <= sin_nxt;
    cos_r <= cos_nxt;
  end

  assign sin_val = sin_r;
  assign cos_val = cos_r;

endmodule
`default_nettype wire

// File: rtl/rpc_rot_cell.sv
// One rotation cell: rotates the (p, q) pair of a vertex by one angle.
`default_nettype none
module rpc_rot_cell
  import rpc_pkg::*;
#(
  parameter int ANGLE_BITS     = 12,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [ANGLE_BITS-1:0] angle,
  input  wire rot_item_t             item_i,
  output rot_item_t                  item_o
);

  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam int PW = COORD_W + TW;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] RND = SW'(1) <<< (TRIG_FRAC_BITS - 1);

  logic signed [TW-1:0] sin_val;
  logic signed [TW-1:0] cos_val;

  rpc_trig #(
    .ANGLE_BITS     (ANGLE_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_trig (
    .clk     (clk),
    .angle   (angle),
    .sin_val (sin_val),
    .cos_val (cos_val)
  );

  // Product stage
  logic                 a_valid_r;
  logic                 a_clip_r;
  coord_t               a_pass_r;
  logic signed [PW-1:0] cp_r;
  logic signed [PW-1:0] sq_r;
  logic signed [PW-1:0] sp_r;
  logic signed [PW-1:0] cq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= item_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    a_clip_r <= item_i.clip;
    a_pass_r <= item_i.r;
    cp_r     <= PW'($signed(item_i.p)) * PW'(cos_val);
    sq_r     <= PW'($signed(item_i.q)) * PW'(sin_val);
    sp_r     <= PW'($signed(item_i.p)) * PW'(sin_val);
    cq_r     <= PW'($signed(item_i.q)) * PW'(cos_val);
  end

  // Sum, round to nearest and saturate
  logic signed [SW-1:0] p_sum;
  logic signed [SW-1:0] q_sum;
  logic signed [SW-1:0] p_shf;
  logic signed [SW-1:0] q_shf;
  logic                 p_ovf;
  logic                 q_ovf;
  rot_item_t            item_nxt;
  rot_item_t            item_r;

  always_comb begin
    p_sum = SW'(cp_r) - SW'(sq_r) + RND;
    q_sum = SW'(sp_r) + SW'(cq_r) + RND;
    p_shf = p_sum >>> TRIG_FRAC_BITS;
    q_shf = q_sum >>> TRIG_FRAC_BITS;
    p_ovf = !((&p_shf[SW-1:COORD_W-1]) || !(|p_shf[SW-1:COORD_W-1]));
    q_ovf = !((&q_shf[SW-1:COORD_W-1]) || !(|q_shf[SW-1:COORD_W-1]));
    item_nxt.valid = a_valid_r;
    item_nxt.clip  = a_clip_r | p_ovf | q_ovf;
    item_nxt.p     = p_ovf ? {p_shf[SW-1], {(COORD_W-1){~p_shf[SW-1]}}}
                           : p_shf[COORD_W-1:0];
    item_nxt.q     = q_ovf ? {q_shf[SW-1], {(COORD_W-1){~q_shf[SW-1]}}}
                           : q_shf[COORD_W-1:0];
    item_nxt.r     = a_pass_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r <= '0;
    end else begin
      item_r <= item_nxt;
    end
  end

  assign item_o = item_r;

  a_cell_latency: assert property (@(posedge clk) disable iff (!rst_n)
    item_o.valid |-> $past(item_i.valid, 2))
    else $error("rotation cell produced a transaction with no input two cycles earlier");

endmodule
`default_nettype wire

// File: bench/rotation_checker.sv
// Checker for the 3-D point rotator: tracks registers, predicts each vertex, compares results.
module rotation_checker
  import rpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  vtx_in_t              in_data,
  input  logic                 out_valid,
  input  vtx_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   mismatches,
  output int                   in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ANG_W  = 12;
  localparam int TRIG_W = 14;
  localparam int QTR    = 1 << (ANG_W - 2);

  longint            sine_quarter [0:QTR];
  logic [ANG_W-1:0]  ang_x, ang_y, ang_z;
  longint            ctr_x, ctr_y, ctr_z;
  vtx_out_t          rotated_q [$];
  int                results_seen;

  // Quarter-wave sine in Q2.30 by Taylor series, rounded to TRIG_W fraction bits.
  function automatic longint quarter_wave(input int r);
    longint unsigned x, x2, term;
    longint          acc;
    x    = 64'(r);
    x    = (x * HALF_PI_Q30) >> (ANG_W - 2);
    x2   = (x * x) >> 30;
    term = x;
    acc  = x;
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / (2 * k * (2 * k + 1));
      if (k % 2) acc = acc - term;
      else       acc = acc + term;
    end
    acc = (acc + (longint'(1) <<< (29 - TRIG_W))) >>> (30 - TRIG_W);
    if (acc < 0) acc = 0;
    if (acc > (longint'(1) <<< TRIG_W)) acc = longint'(1) <<< TRIG_W;
    return acc;
  endfunction

  function automatic longint sin_lookup(input logic [ANG_W-1:0] a);
    int     idx;
    longint v;
    idx = a[ANG_W-2] ? QTR - int'(a[ANG_W-3:0]) : int'(a[ANG_W-3:0]);
    v   = sine_quarter[idx];
    return a[ANG_W-1] ? -v : v;
  endfunction

  function automatic longint clamp_to(input longint v, input int w, inout bit hit);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Rotate the pair (p, q) by angle a; both outputs come from the old values.
  function automatic void spin(inout longint p, inout longint q,
                               input logic [ANG_W-1:0] a, inout bit hit);
    longint c, s, np, nq;
    c  = sin_lookup(a + ANG_W'(QTR));
    s  = sin_lookup(a);
    np = (c * p - s * q + (longint'(1) <<< (TRIG_W - 1))) >>> TRIG_W;
    nq = (s * p + c * q + (longint'(1) <<< (TRIG_W - 1))) >>> TRIG_W;
    p  = clamp_to(np, COORD_W, hit);
    q  = clamp_to(nq, COORD_W, hit);
  endfunction

  function automatic vtx_out_t predict_rotation(input vtx_in_t v);
    longint   x, y, z;
    bit       hit;
    vtx_out_t res;
    hit = 1'b0;
    x = clamp_to(longint'($signed(v.in_x)) - ctr_x, COORD_W, hit);
    y = clamp_to(longint'($signed(v.in_y)) - ctr_y, COORD_W, hit);
    z = clamp_to(longint'($signed(v.in_z)) - ctr_z, COORD_W, hit);
    spin(y, z, ang_x, hit);
    spin(x, z, ang_y, hit);
    spin(x, y, ang_z, hit);
    x = clamp_to(x + ctr_x, COORD_W, hit);
    y = clamp_to(y + ctr_y, COORD_W, hit);
    z = clamp_to(z + ctr_z, COORD_W, hit);
    res.out_x   = x[COORD_W-1:0];
    res.out_y   = y[COORD_W-1:0];
    res.out_z   = z[COORD_W-1:0];
    res.pixel_x = pix_t'(clamp_to(x >>> FRAC_BITS, PIX_W, hit));
    res.pixel_y = pix_t'(clamp_to(y >>> FRAC_BITS, PIX_W, hit));
    res.clipped = hit;
    return res;
  endfunction

  initial begin
    mismatches   = 0;
    in_flight    = 0;
    results_seen = 0;
    for (int i = 0; i <= QTR; i++) sine_quarter[i] = quarter_wave(i);
  end

  always @(posedge clk) begin : watch
    vtx_out_t want;
    if (!rst_n) begin
      ang_x = ANG_W'(ANGLE_X_RST);
      ang_y = ANG_W'(ANGLE_Y_RST);
      ang_z = ANG_W'(ANGLE_Z_RST);
      ctr_x = longint'(CENTRE_RST);
      ctr_y = longint'(CENTRE_RST);
      ctr_z = longint'(CENTRE_RST);
      rotated_q.delete();
    end else begin
      if (out_valid) begin
        results_seen++;
        if (rotated_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: none expected, got x=%0d y=%0d z=%0d px=%0d py=%0d clip=%b",
                     results_seen, out_data.out_x, out_data.out_y, out_data.out_z,
                     out_data.pixel_x, out_data.pixel_y, out_data.clipped);
        end else begin
          want = rotated_q.pop_front();
          if (out_data.out_x !== want.out_x || out_data.out_y !== want.out_y ||
              out_data.out_z !== want.out_z || out_data.pixel_x !== want.pixel_x ||
              out_data.pixel_y !== want.pixel_y || out_data.clipped !== want.clipped) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d: expected x=%0d y=%0d z=%0d px=%0d py=%0d clip=%b",
                       results_seen, want.out_x, want.out_y, want.out_z,
                       want.pixel_x, want.pixel_y, want.clipped);
              $display("result %0d:      got x=%0d y=%0d z=%0d px=%0d py=%0d clip=%b",
                       results_seen, out_data.out_x, out_data.out_y, out_data.out_z,
                       out_data.pixel_x, out_data.pixel_y, out_data.clipped);
            end
          end
        end
      end
      // Predict with the registers as they stand before any write at this edge.
      if (start && !busy) rotated_q.push_back(predict_rotation(in_data));
      if (cfg_we) begin
        case (cfg_idx)
          CFG_ANGLE_X:  ang_x = cfg_wdata[ANG_W-1:0];
          CFG_ANGLE_Y:  ang_y = cfg_wdata[ANG_W-1:0];
          CFG_ANGLE_Z:  ang_z = cfg_wdata[ANG_W-1:0];
          CFG_CENTRE_X: ctr_x = longint'($signed(cfg_wdata[COORD_W-1:0]));
          CFG_CENTRE_Y: ctr_y = longint'($signed(cfg_wdata[COORD_W-1:0]));
          CFG_CENTRE_Z: ctr_z = longint'($signed(cfg_wdata[COORD_W-1:0]));
          default: ;
        endcase
      end
    end
    in_flight = rotated_q.size();
  end

endmodule

// File: bench/testbench.sv
// Top of the rotator testbench: clock, reset, vertex and register stimulus, verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rpc_pkg::*;

  // Pipeline depth from start transaction to result strobe, plus margin.
  localparam int DUT_LATENCY = 10;
  localparam int SETTLE      = DUT_LATENCY + 6;
  localparam int PHASES      = 12;
  localparam int PER_PHASE   = 130;

  localparam coord_t C_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t C_MIN  = {1'b1, {(COORD_W-1){1'b0}}};
  localparam coord_t C_ZERO = '0;
  localparam coord_t C_ONE  = coord_t'(1);
  localparam coord_t C_NEG1 = '1;

  localparam logic [11:0] ANG_ZERO    = 12'd0;
  localparam logic [11:0] ANG_EIGHTH  = 12'd512;
  localparam logic [11:0] ANG_QUARTER = 12'd1024;
  localparam logic [11:0] ANG_HALF    = 12'd2048;
  localparam logic [11:0] ANG_3QUART  = 12'd3072;
  localparam logic [11:0] ANG_TOP     = 12'd4095;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  vtx_in_t              in_data;
  logic                 out_valid;
  vtx_out_t             out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   mismatches;
  int                   in_flight;

  // Centre currently programmed, so vertices can be aimed near it.
  coord_t cur_cx, cur_cy, cur_cz;

  always #6 clk = ~clk;

  rotate_point_3d_about_centre dut (.*);

  rotation_checker checker_i (.*);

  function automatic vtx_in_t vtx(input coord_t x, input coord_t y, input coord_t z);
    vtx_in_t v;
    v.in_x = x;
    v.in_y = y;
    v.in_z = z;
    return v;
  endfunction

  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  // Mix of full-range, near-centre, extreme and mid-range values.
  function automatic coord_t pick_coord(input coord_t near);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return rand_coord();
      4, 5, 6:    return near + coord_t'(int'($urandom_range(0, 8191)) - 4096);
      7: begin
        case ($urandom_range(0, 4))
          0:       return C_MAX;
          1:       return C_MIN;
          2:       return C_ZERO;
          3:       return C_NEG1;
          default: return C_ONE;
        endcase
      end
      default:    return coord_t'(int'($urandom_range(0, 65535)) - 32768);
    endcase
  endfunction

  function automatic logic [11:0] pick_angle();
    case ($urandom_range(0, 9))
      0:       return ANG_ZERO;
      1:       return ANG_TOP;
      2:       return {2'($urandom_range(0, 3)), 10'd0};
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic coord_t pick_centre();
    case ($urandom_range(0, 9))
      0:          return C_MAX;
      1:          return C_MIN;
      2:          return C_ZERO;
      3, 4, 5:    return rand_coord();
      default:    return coord_t'(int'($urandom_range(0, 131071)) - 65536);
    endcase
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction,
  // with start still high so a following vertex can go out back-to-back.
  task automatic put_vertex(input vtx_in_t v);
    start   <= 1'b1;
    in_data <= v;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  // Drop start over the requested gap and put noise on the data lines.
  task automatic pause(input int n);
    if (n > 0) begin
      start   <= 1'b0;
      in_data <= vtx(rand_coord(), rand_coord(), rand_coord());
      repeat (n) @(negedge clk);
    end
  endtask

  // Hold off until every predicted result has come back, then let the pipe settle.
  task automatic drain();
    start <= 1'b0;
    while (in_flight != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  // Program all six registers; angle words carry junk above bit 11, which must be dropped.
  task automatic program_regs(input logic [11:0] ax, input logic [11:0] ay,
                              input logic [11:0] az, input coord_t cx,
                              input coord_t cy, input coord_t cz);
    logic [CFG_W-1:0] w;
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_IDX_W'($urandom_range(int'(CFG_CENTRE_Z) + 1, (1 << CFG_IDX_W) - 1)),
                CFG_W'($urandom));
    w = CFG_W'($urandom); w[11:0] = ax;
    write_reg(CFG_ANGLE_X, w);
    w = CFG_W'($urandom); w[11:0] = ay;
    write_reg(CFG_ANGLE_Y, w);
    w = CFG_W'($urandom); w[11:0] = az;
    write_reg(CFG_ANGLE_Z, w);
    write_reg(CFG_CENTRE_X, cx);
    write_reg(CFG_CENTRE_Y, cy);
    write_reg(CFG_CENTRE_Z, cz);
    cfg_we <= 1'b0;
    cur_cx = cx;
    cur_cy = cy;
    cur_cz = cz;
  endtask

  // Hard stop in case a handshake or a result never arrives.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    cur_cx    = coord_t'(CENTRE_RST);
    cur_cy    = coord_t'(CENTRE_RST);
    cur_cz    = coord_t'(CENTRE_RST);
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Reset register values: vertex at the centre, origin, mixed extremes.
    put_vertex(vtx(coord_t'(CENTRE_RST), coord_t'(CENTRE_RST), coord_t'(CENTRE_RST)));
    put_vertex(vtx(C_ZERO, C_ZERO, C_ZERO));
    put_vertex(vtx(C_MAX, C_MIN, C_ZERO));
    drain();

    // Identity rotation about the origin: values must pass through unchanged.
    program_regs(ANG_ZERO, ANG_ZERO, ANG_ZERO, C_ZERO, C_ZERO, C_ZERO);
    put_vertex(vtx(C_MAX, C_MAX, C_MAX));
    put_vertex(vtx(C_MIN, C_MIN, C_MIN));
    put_vertex(vtx(C_ZERO, C_ZERO, C_ZERO));
    put_vertex(vtx(C_NEG1, C_NEG1, C_NEG1));
    put_vertex(vtx(C_MAX, C_MIN, C_ONE));
    drain();

    // Exact quadrant angles on every axis.
    program_regs(ANG_QUARTER, ANG_HALF, ANG_3QUART, C_ZERO, C_ZERO, C_ZERO);
    put_vertex(vtx(coord_t'(256), coord_t'(512), coord_t'(-768)));
    put_vertex(vtx(C_MAX, C_ZERO, C_MIN));
    drain();

    // Eighth turns grow a full-scale corner past the range: rotation saturates.
    program_regs(ANG_EIGHTH, ANG_EIGHTH, ANG_EIGHTH, C_ZERO, C_ZERO, C_ZERO);
    put_vertex(vtx(C_MAX, C_MAX, C_MAX));
    put_vertex(vtx(C_MIN, C_MAX, C_MIN));
    put_vertex(vtx(C_ONE, C_ONE, C_ONE));
    drain();

    // Centre at the top of the range: the subtract and the add-back both saturate.
    program_regs(ANG_HALF, ANG_ZERO, ANG_ZERO, C_MAX, C_MAX, C_MAX);
    put_vertex(vtx(C_MIN, C_MIN, C_MIN));
    put_vertex(vtx(C_MAX, C_MAX, C_MAX));
    put_vertex(vtx(C_ZERO, C_NEG1, C_ONE));
    drain();

    // Centre at the bottom of the range, largest angle code.
    program_regs(ANG_ZERO, ANG_HALF, ANG_TOP, C_MIN, C_MIN, C_MIN);
    put_vertex(vtx(C_MAX, C_ZERO, C_MIN));
    put_vertex(vtx(C_MIN, C_MAX, C_ZERO));
    drain();

    // Random phases: one register setting each, every third phase without gaps.
    for (int ph = 0; ph < PHASES; ph++) begin
      program_regs(pick_angle(), pick_angle(), pick_angle(),
                   pick_centre(), pick_centre(), pick_centre());
      for (int n = 0; n < PER_PHASE; n++) begin
        put_vertex(vtx(pick_coord(cur_cx), pick_coord(cur_cy), pick_coord(cur_cz)));
        if (ph % 3 != 0) pause(pick_gap());
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/rpc_pkg.sv
rtl/rpc_trig.sv
rtl/rpc_rot_cell.sv
rtl/rotate_point_3d_about_centre.sv
bench/rotation_checker.sv
bench/testbench.sv
